[hw/rtl/slre_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_pkg
// Shared types, register codes and fixed-point helpers of the regression engine.
// ----------------------------------------------------------------------------
package slre_pkg;

    // wide working width for sums and products before saturation
    localparam int WIDE = 80;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 31;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARNING_RATE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FEATURE_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHUFFLE_MULT   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPLIT_SEED     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRAIN_PERCENT  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EPOCH_LIMIT    = 3'd6;

    // register reset values
    localparam logic [30:0] RST_LEARNING_RATE = 31'd167772;
    localparam logic [3:0]  RST_FEATURE_COUNT = 4'd7;
    localparam logic [16:0] RST_ROW_COUNT     = 17'd65536;
    localparam logic [19:0] RST_SHUFFLE_MULT  = 20'd55;
    localparam logic [15:0] RST_SPLIT_SEED    = 16'd0;
    localparam logic [6:0]  RST_TRAIN_PERCENT = 7'd80;
    localparam logic [15:0] RST_EPOCH_LIMIT   = 16'd100;

    localparam logic [15:0] EPOCH_MAX = 16'hFFFF;

    // action codes
    localparam logic [1:0] ACT_TRAIN   = 2'd0;
    localparam logic [1:0] ACT_PREDICT = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    localparam logic signed [WIDE-1:0] W_MAX  = 80'sh7FFF_FFFF;
    localparam logic signed [WIDE-1:0] W_MIN  = -W_MAX - 80'sd1;
    localparam logic signed [WIDE-1:0] W_HALF = 80'sh80_0000;

    // per-cell control
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
        logic signed [31:0] r;
        if (v > W_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < W_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // drop 24 fraction bits, rounding half up
    function automatic logic signed [WIDE-1:0] round24(input logic signed [WIDE-1:0] v);
        logic signed [WIDE-1:0] r;
        r = (v + W_HALF) >>> 24;
        return r;
    endfunction

endpackage

[hw/rtl/slre_sample_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_sample_if
// Input word channel: one row element per word.
// ----------------------------------------------------------------------------
interface slre_sample_if #(
    parameter int ROW_INDEX_BITS = 16
);
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [ROW_INDEX_BITS-1:0] row_index;
    logic signed [31:0]        value;
    logic                      is_target;

    modport source (output valid, action, row_index, value, is_target, input ready);
    modport sink   (input valid, action, row_index, value, is_target, output ready);
endinterface

[hw/rtl/slre_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_result_if
// Result word channel: prediction and error of one row.
// ----------------------------------------------------------------------------
interface slre_result_if;
    logic               valid;
    logic               ready;
    logic               selected;
    logic               was_training;
    logic signed [31:0] prediction;
    logic signed [31:0] error;

    modport source (output valid, selected, was_training, prediction, error, input ready);
    modport sink   (input valid, selected, was_training, prediction, error, output ready);
endinterface

[hw/rtl/slre_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_cell
// One ring cell: holds a weight and its buffered feature, passes both on.
// ----------------------------------------------------------------------------
module slre_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slre_pkg::cell_ctrl_t ctrl,
    input  logic                 load,
    input  logic signed [31:0]   load_x,
    input  logic signed [31:0]   w_nb,
    input  logic signed [31:0]   x_nb,
    output logic signed [31:0]   w,
    output logic signed [31:0]   x
);
    logic signed [31:0] w_reg;
    logic signed [31:0] x_reg;

    // weight: cleared by reset and clear, rotates with the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_reg <= '0;
        else if (ctrl.clear)
            w_reg <= '0;
        else if (ctrl.shift)
            w_reg <= w_nb;
    end

    // feature: written by its own element, rotates with the ring
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
            x_reg <= x_nb;
        else if (load)
            x_reg <= load_x;
    end

    assign w = w_reg;
    assign x = x_reg;
endmodule

[hw/rtl/slre_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module slre_mod #(
    parameter int DW = 37
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [16:0]   divisor,
    output logic          done,
    output logic [16:0]   remainder
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg;
    logic [16:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [17:0]   trial;

    // shift in the next bit and subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DW-1]};
        if (trial >= {1'b0, divisor})
            trial = trial - {1'b0, divisor};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= trial[16:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

[hw/rtl/sgd_linear_regression_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_linear_regression_engine_top
// Linear regressor trained per row by gradient descent, signed Q8.24.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  samples   in         action, row_index, value, is_target
//  results   out        selected, was_training, prediction, error
//  cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
//  feature words, clear and unused actions leave the sequencer idle
//  a target word runs the bit-serial split remainder (ROW_INDEX_BITS + 21
//  steps), then for a selected row one full turn of the cell ring to predict
//  and, when it updates, a second one, both through the one shared multiplier
//  reset loads register defaults, clears model and counters; no clearing pass
//  a held result word does not block new feature words
// ----------------------------------------------------------------------------
module sgd_linear_regression_engine_top #(
    parameter int MAX_FEATURES   = 8,
    parameter int ROW_INDEX_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [slre_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [slre_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    slre_sample_if.sink                               samples,
    slre_result_if.source                             results
);
    localparam int NW = $clog2(MAX_FEATURES + 1);
    localparam int DW = ROW_INDEX_BITS + 21;
    localparam int AW = 65 + $clog2(MAX_FEATURES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPLIT = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_PRED  = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_ERR   = 4'd6;
    localparam logic [3:0] S_GMUL  = 4'd7;
    localparam logic [3:0] S_GRND  = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // configuration registers
    logic [30:0] lr_reg;
    logic [3:0]  fcount_reg;
    logic [16:0] rcount_reg;
    logic [19:0] mult_reg;
    logic [15:0] seed_reg;
    logic [6:0]  pct_reg;
    logic [15:0] elimit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg     <= slre_pkg::RST_LEARNING_RATE;
            fcount_reg <= slre_pkg::RST_FEATURE_COUNT;
            rcount_reg <= slre_pkg::RST_ROW_COUNT;
            mult_reg   <= slre_pkg::RST_SHUFFLE_MULT;
            seed_reg   <= slre_pkg::RST_SPLIT_SEED;
            pct_reg    <= slre_pkg::RST_TRAIN_PERCENT;
            elimit_reg <= slre_pkg::RST_EPOCH_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slre_pkg::CFG_LEARNING_RATE: lr_reg     <= cfg_data;
                slre_pkg::CFG_FEATURE_COUNT: fcount_reg <= cfg_data[3:0];
                slre_pkg::CFG_ROW_COUNT:     rcount_reg <= cfg_data[16:0];
                slre_pkg::CFG_SHUFFLE_MULT:  mult_reg   <= cfg_data[19:0];
                slre_pkg::CFG_SPLIT_SEED:    seed_reg   <= cfg_data[15:0];
                slre_pkg::CFG_TRAIN_PERCENT: pct_reg    <= cfg_data[6:0];
                slre_pkg::CFG_EPOCH_LIMIT:   elimit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control and row state
    logic [3:0]                state_reg, state_next;
    logic [NW-1:0]             elem_reg;
    logic [NW-1:0]             k_reg;
    logic                      phase_reg;
    logic [15:0]               epochs_reg;
    logic                      training_reg;
    logic                      sel_reg;
    logic [ROW_INDEX_BITS-1:0] idx_reg;
    logic signed [31:0]        target_reg;
    logic signed [AW-1:0]      acc_reg;
    logic signed [63:0]        prod_reg;
    logic signed [31:0]        pred_reg;
    logic signed [31:0]        err_reg;
    logic signed [31:0]        g_reg;
    logic signed [31:0]        bias_reg;
    logic                      out_valid_reg;
    logic                      out_sel_reg;
    logic                      out_train_reg;
    logic signed [31:0]        out_pred_reg;
    logic signed [31:0]        out_err_reg;

    logic [NW-1:0] n_eff;
    assign n_eff = (32'(fcount_reg) >= MAX_FEATURES) ? NW'(MAX_FEATURES) : NW'(fcount_reg);

    logic accept;
    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;

    logic is_feat, is_tgt, is_clear;
    assign is_clear = accept && (samples.action == slre_pkg::ACT_CLEAR);
    assign is_feat  = accept && !samples.is_target &&
                      ((samples.action == slre_pkg::ACT_TRAIN) ||
                       (samples.action == slre_pkg::ACT_PREDICT));
    assign is_tgt   = accept && samples.is_target &&
                      ((samples.action == slre_pkg::ACT_TRAIN) ||
                       (samples.action == slre_pkg::ACT_PREDICT));

    // ring of cells
    logic signed [31:0]   cw [MAX_FEATURES];
    logic signed [31:0]   cx [MAX_FEATURES];
    logic signed [31:0]   head_w_ret;
    logic signed [31:0]   w_new;
    logic                 active;
    logic                 rotate;
    slre_pkg::cell_ctrl_t ctrl;

    assign active      = (k_reg < n_eff);
    assign rotate      = ((state_reg == S_PRED) || (state_reg == S_UPD)) && phase_reg;
    assign ctrl.clear  = is_clear;
    assign ctrl.shift  = rotate;
    assign w_new       = slre_pkg::sat32(slre_pkg::WIDE'(cw[0]) +
                                         slre_pkg::round24(slre_pkg::WIDE'(prod_reg)));
    assign head_w_ret  = ((state_reg == S_UPD) && active) ? w_new : cw[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FEATURES; gi++)
        begin : g_cell
            logic signed [31:0] w_nb, x_nb;
            if (gi == MAX_FEATURES - 1)
            begin : g_last
                assign w_nb = head_w_ret;
                assign x_nb = cx[0];
            end
            else
            begin : g_mid
                assign w_nb = cw[gi+1];
                assign x_nb = cx[gi+1];
            end
            slre_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .load   (is_feat && (elem_reg < n_eff) && (elem_reg == NW'(gi))),
                .load_x (samples.value),
                .w_nb   (w_nb),
                .x_nb   (x_nb),
                .w      (cw[gi]),
                .x      (cx[gi])
            );
        end
    endgenerate

    // split remainder unit
    logic          div_done;
    logic [16:0]   pos;
    logic [DW-1:0] dividend;
    assign dividend = DW'(idx_reg * mult_reg) + DW'(seed_reg);

    slre_mod #(.DW(DW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_SPLIT),
        .dividend  (dividend),
        .divisor   (rcount_reg),
        .done      (div_done),
        .remainder (pos)
    );

    // training part test: pos < floor(rc*pct/100) <=> 100*(pos+1) <= rc*pct
    logic [24:0] part_lhs, part_rhs;
    logic        in_train;
    assign part_lhs = 25'((25'(pos) + 25'd1) * 25'd100);
    assign part_rhs = 25'(25'(rcount_reg) * 25'(pct_reg));
    assign in_train = (rcount_reg != 17'd0) && (part_lhs <= part_rhs);

    // shared multiplier operands
    logic signed [31:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = cw[0];
        mul_b = cx[0];
        if (state_reg == S_UPD)
            mul_a = g_reg;
        else if (state_reg == S_GMUL)
        begin
            mul_a = $signed({1'b0, lr_reg});
            mul_b = err_reg;
        end
    end

    logic do_update, epoch_end, out_free;
    assign do_update = training_reg && (epochs_reg < elimit_reg);
    assign epoch_end = training_reg && (rcount_reg != 17'd0) &&
                       (33'(idx_reg) == 33'(rcount_reg) - 33'd1);
    assign out_free  = !out_valid_reg || results.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (is_tgt) state_next = S_SPLIT;
            S_SPLIT: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_CMP;
            S_CMP:   state_next = (training_reg ? in_train : !in_train) ? S_PRED : S_DONE;
            S_PRED:  if (phase_reg && (k_reg == NW'(MAX_FEATURES - 1))) state_next = S_FIN;
            S_FIN:   state_next = S_ERR;
            S_ERR:   state_next = do_update ? S_GMUL : S_DONE;
            S_GMUL:  state_next = S_GRND;
            S_GRND:  state_next = S_UPD;
            S_UPD:   if (phase_reg && (k_reg == NW'(MAX_FEATURES - 1))) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            elem_reg      <= '0;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
            epochs_reg    <= '0;
            bias_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // element counter
            if (is_clear || is_tgt)
                elem_reg <= '0;
            else if (is_feat && (elem_reg < n_eff))
                elem_reg <= elem_reg + NW'(1);
            // ring step counter
            if ((state_reg == S_PRED) || (state_reg == S_UPD))
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                    k_reg <= (k_reg == NW'(MAX_FEATURES - 1)) ? '0 : k_reg + NW'(1);
            end
            // bias
            if (is_clear)
                bias_reg <= '0;
            else if ((state_reg == S_UPD) && (k_reg == '0) && !phase_reg)
                bias_reg <= slre_pkg::sat32(slre_pkg::WIDE'(bias_reg) +
                                            slre_pkg::WIDE'(g_reg));
            // epochs and result handoff
            if (is_clear)
                epochs_reg <= '0;
            else if ((state_reg == S_DONE) && out_free && epoch_end &&
                     (epochs_reg != slre_pkg::EPOCH_MAX))
                epochs_reg <= epochs_reg + 16'd1;
            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (is_tgt)
        begin
            idx_reg      <= samples.row_index;
            target_reg   <= samples.value;
            training_reg <= (samples.action == slre_pkg::ACT_TRAIN);
        end
        if (state_reg == S_CMP)
        begin
            sel_reg  <= training_reg ? in_train : !in_train;
            acc_reg  <= '0;
            pred_reg <= '0;
            err_reg  <= '0;
        end
        prod_reg <= mul_a * mul_b;
        if ((state_reg == S_PRED) && phase_reg && active)
            acc_reg <= acc_reg + AW'(prod_reg);
        if (state_reg == S_FIN)
            pred_reg <= slre_pkg::sat32((slre_pkg::WIDE'(acc_reg) +
                                         (slre_pkg::WIDE'(bias_reg) <<< 24) +
                                         slre_pkg::W_HALF) >>> 24);
        if (state_reg == S_ERR)
            err_reg <= slre_pkg::sat32(slre_pkg::WIDE'(target_reg) -
                                       slre_pkg::WIDE'(pred_reg));
        if (state_reg == S_GRND)
            g_reg <= slre_pkg::sat32(slre_pkg::round24(slre_pkg::WIDE'(prod_reg)));
        if ((state_reg == S_DONE) && out_free)
        begin
            out_sel_reg   <= sel_reg;
            out_train_reg <= training_reg;
            out_pred_reg  <= pred_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.selected     = out_sel_reg;
    assign results.was_training = out_train_reg;
    assign results.prediction   = out_pred_reg;
    assign results.error        = out_err_reg;

    // the ring is back in its home position whenever no row is in flight
    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (k_reg == '0 && !phase_reg))
        else $error("cell ring left misaligned");

    // the remainder only completes while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder done outside wait");

    // the element counter never passes the ring length
    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(elem_reg) <= MAX_FEATURES)
        else $error("element counter out of range");

    // a result word is loaded only when the output is free
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !results.ready) |=> (state_reg == S_DONE))
        else $error("result overwritten");
endmodule

[dv/tb_sgd_linear_regression_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sgd_linear_regression_engine_top
// Self-checking bench for the gradient-descent regression engine: a directed
// table of words, then phases of random rows under several register settings
// and idle patterns, each result checked against a table entry or an in-bench Q8.24 model.
// ----------------------------------------------------------------------------
module tb_sgd_linear_regression_engine_top;

    localparam int NFEAT = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 150;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        bit                 sel;
        bit                 trn;
        logic signed [31:0] pred;
        logic signed [31:0] err;
    } row_result_t;

    typedef struct {
        logic [1:0]         act;
        logic [15:0]        row;
        logic signed [31:0] val;
        bit                 tgt;
        bit                 known;
        bit                 e_sel;
        bit                 e_trn;
        logic signed [31:0] e_pred;
        logic signed [31:0] e_err;
    } dir_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [slre_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [slre_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    slre_sample_if #(.ROW_INDEX_BITS(16)) samples ();
    slre_result_if results ();

    sgd_linear_regression_engine_top #(
        .MAX_FEATURES(NFEAT),
        .ROW_INDEX_BITS(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .samples(samples),
        .results(results)
    );

    // model copy of registers and state
    logic [30:0] m_rate;
    logic [3:0]  m_fcount;
    logic [16:0] m_rows;
    logic [19:0] m_mult;
    logic [15:0] m_seed;
    logic [6:0]  m_pct;
    logic [15:0] m_elimit;
    logic signed [31:0] m_w [NFEAT];
    logic signed [31:0] m_bias;
    logic signed [31:0] m_buf [NFEAT];
    int unsigned m_cnt;
    logic [15:0] m_epochs;

    row_result_t pending_results [$];
    int mismatches = 0;
    int cycles = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat_q(input logic signed [slre_pkg::WIDE-1:0] v);
        if (v > 80'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -80'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [slre_pkg::WIDE-1:0] round_q(
        input logic signed [slre_pkg::WIDE-1:0] v);
        return (v + 80'sh80_0000) >>> 24;
    endfunction

    function automatic bit in_train_part(input logic [15:0] idx);
        longint unsigned pos;
        longint unsigned lim;
        if (m_rows == 0)
            return 1'b0;
        pos = (longint'(idx) * longint'(m_mult) + longint'(m_seed)) % longint'(m_rows);
        lim = (longint'(m_rows) * longint'(m_pct)) / 100;
        return pos < lim;
    endfunction

    function automatic int unsigned active_count();
        return (m_fcount < NFEAT) ? m_fcount : NFEAT;
    endfunction

    // lms model: one accepted word, zero or one row result
    task automatic lms_predict_word(input logic [1:0] act, input logic [15:0] idx,
                                    input logic signed [31:0] val, input bit tgt);
        row_result_t r;
        logic signed [slre_pkg::WIDE-1:0] acc;
        logic signed [slre_pkg::WIDE-1:0] t;
        logic signed [31:0] g;
        int unsigned n;
        n = active_count();
        if (act == ACT_UNUSED)
            return;
        if (act == slre_pkg::ACT_CLEAR)
        begin
            foreach (m_w[i]) m_w[i] = '0;
            m_bias = '0;
            m_cnt = 0;
            m_epochs = '0;
            return;
        end
        if (!tgt)
        begin
            if (m_cnt < n)
            begin
                m_buf[m_cnt] = val;
                m_cnt++;
            end
            return;
        end
        m_cnt = 0;
        r.trn = (act == slre_pkg::ACT_TRAIN);
        r.sel = r.trn ? in_train_part(idx) : !in_train_part(idx);
        r.pred = '0;
        r.err = '0;
        if (r.sel)
        begin
            acc = m_bias;
            acc = acc <<< 24;
            for (int i = 0; i < n; i++)
            begin
                t = m_w[i];
                t = t * m_buf[i];
                acc = acc + t;
            end
            r.pred = sat_q(round_q(acc));
            t = val;
            t = t - r.pred;
            r.err = sat_q(t);
            if (r.trn && m_epochs < m_elimit)
            begin
                t = $signed({49'b0, m_rate});
                t = t * r.err;
                g = sat_q(round_q(t));
                t = m_bias;
                t = t + g;
                m_bias = sat_q(t);
                for (int i = 0; i < n; i++)
                begin
                    t = g;
                    t = t * m_buf[i];
                    acc = m_w[i];
                    acc = acc + round_q(t);
                    m_w[i] = sat_q(acc);
                end
            end
        end
        // epoch end on last row, selected or not
        if (r.trn && m_rows != 0 && {1'b0, idx} == m_rows - 17'd1 &&
            m_epochs != slre_pkg::EPOCH_MAX)
            m_epochs++;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected word", results.prediction, '0);
            else
            begin
                row_result_t e;
                e = pending_results.pop_front();
                if (results.selected !== e.sel)
                    flag_mismatch("selected", results.selected, e.sel);
                if (results.was_training !== e.trn)
                    flag_mismatch("was_training", results.was_training, e.trn);
                if (results.prediction !== e.pred)
                    flag_mismatch("prediction", results.prediction, e.pred);
                if (results.error !== e.err)
                    flag_mismatch("error", results.error, e.err);
            end
        end
    end

    // result stall
    always @(negedge clk)
        results.ready <= ($urandom_range(99) >= snk_stall_pct);

    // send one word, with random idle before it
    task automatic send_word(input logic [1:0] act, input logic [15:0] idx,
                             input logic signed [31:0] val, input bit tgt);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            samples.valid = 1'b0;
            @(negedge clk);
        end
        samples.valid = 1'b1;
        samples.action = act;
        samples.row_index = idx;
        samples.value = val;
        samples.is_target = tgt;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        lms_predict_word(act, idx, val, tgt);
    endtask

    task automatic drain();
        @(negedge clk);
        samples.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [slre_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [30:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        case (idx)
            slre_pkg::CFG_LEARNING_RATE: m_rate = data;
            slre_pkg::CFG_FEATURE_COUNT: m_fcount = data[3:0];
            slre_pkg::CFG_ROW_COUNT:     m_rows = data[16:0];
            slre_pkg::CFG_SHUFFLE_MULT:  m_mult = data[19:0];
            slre_pkg::CFG_SPLIT_SEED:    m_seed = data[15:0];
            slre_pkg::CFG_TRAIN_PERCENT: m_pct = data[6:0];
            slre_pkg::CFG_EPOCH_LIMIT:   m_elimit = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    // random rows: mostly well-formed, some noise
    task automatic random_rows(input int count);
        int done;
        int nf;
        logic [15:0] row;
        logic [1:0] act;
        done = 0;
        row = '0;
        while (done < count)
        begin
            if ($urandom_range(99) < 8)
            begin
                case ($urandom_range(2))
                    0: send_word(slre_pkg::ACT_CLEAR, 16'($urandom), $urandom,
                                 1'($urandom_range(1)));
                    1: send_word(ACT_UNUSED, 16'($urandom), $urandom,
                                 1'($urandom_range(1)));
                    default: send_word(slre_pkg::ACT_PREDICT, 16'($urandom),
                                       rand_value(), 1'b1);
                endcase
                done++;
                continue;
            end
            act = ($urandom_range(99) < 65) ? slre_pkg::ACT_TRAIN : slre_pkg::ACT_PREDICT;
            if ($urandom_range(3) == 0)
                row = 16'($urandom);
            else if (m_rows != 0 && m_rows <= 17'd65536)
                row = 16'(({1'b0, row} + 17'd1) % m_rows);
            else
                row = row + 16'd1;
            nf = m_fcount;
            if ($urandom_range(9) == 0)
                nf = $urandom_range(10);
            for (int i = 0; i < nf; i++)
            begin
                send_word(act, row, rand_value(), 1'b0);
                done++;
            end
            send_word(act, row, rand_value(), 1'b1);
            done++;
        end
    endtask

    task automatic set_all(input logic [30:0] rate, input logic [3:0] fc,
                           input logic [16:0] rc, input logic [19:0] mult,
                           input logic [15:0] seed, input logic [6:0] pct,
                           input logic [15:0] elim);
        write_reg(slre_pkg::CFG_LEARNING_RATE, rate);
        write_reg(slre_pkg::CFG_FEATURE_COUNT, 31'(fc));
        write_reg(slre_pkg::CFG_ROW_COUNT, 31'(rc));
        write_reg(slre_pkg::CFG_SHUFFLE_MULT, 31'(mult));
        write_reg(slre_pkg::CFG_SPLIT_SEED, 31'(seed));
        write_reg(slre_pkg::CFG_TRAIN_PERCENT, 31'(pct));
        write_reg(slre_pkg::CFG_EPOCH_LIMIT, 31'(elim));
    endtask

    // directed words; typed expectations where the model state is trivially zero
    dir_word_t dir_tab [23] = '{
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'sh7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'sh8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'sh0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'sh0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'shFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'sh0100_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'shFF00_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'sh0080_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        // row 0 sits in the training part: predict gives an unselected row
        '{slre_pkg::ACT_PREDICT, 16'd0, 32'sh1234_5678, 1'b1, 1'b1, 1'b0, 1'b0, 32'sd0, 32'sd0},
        // zero model: error equals target
        '{slre_pkg::ACT_TRAIN, 16'd0, 32'sh0100_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'sd0,
          32'sh0100_0000},
        // unused action is ignored
        '{ACT_UNUSED, 16'd0, 32'sh0100_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_CLEAR, 16'd0, 32'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_TRAIN, 16'd0, 32'sh8000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'sd0,
          32'sh8000_0000},
        '{slre_pkg::ACT_TRAIN, 16'd0, 32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        // short row keeps older buffer entries
        '{slre_pkg::ACT_TRAIN, 16'd3, 32'sh0040_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_TRAIN, 16'd3, 32'shFFC0_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_TRAIN, 16'd3, 32'sh7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_TRAIN, 16'd3, 32'sh0200_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        // last row ends an epoch
        '{slre_pkg::ACT_TRAIN, 16'hFFFF, 32'shFE00_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'hFFFF, 32'sh0300_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0,
          32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'h1234, 32'sh0080_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0,
          32'sd0},
        '{slre_pkg::ACT_CLEAR, 16'hABCD, 32'sh5555_5555, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{slre_pkg::ACT_PREDICT, 16'd5, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0}
    };

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.action = slre_pkg::ACT_TRAIN;
        samples.row_index = '0;
        samples.value = '0;
        samples.is_target = 1'b0;
        m_rate = slre_pkg::RST_LEARNING_RATE;
        m_fcount = slre_pkg::RST_FEATURE_COUNT;
        m_rows = slre_pkg::RST_ROW_COUNT;
        m_mult = slre_pkg::RST_SHUFFLE_MULT;
        m_seed = slre_pkg::RST_SPLIT_SEED;
        m_pct = slre_pkg::RST_TRAIN_PERCENT;
        m_elimit = slre_pkg::RST_EPOCH_LIMIT;
        foreach (m_w[i]) m_w[i] = '0;
        foreach (m_buf[i]) m_buf[i] = '0;
        m_bias = '0;
        m_cnt = 0;
        m_epochs = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full-width rows so every buffer entry is written before use
        write_reg(slre_pkg::CFG_FEATURE_COUNT, 31'd8);

        // directed table
        foreach (dir_tab[k])
        begin
            send_word(dir_tab[k].act, dir_tab[k].row, dir_tab[k].val, dir_tab[k].tgt);
            if (dir_tab[k].known)
            begin
                pending_results[$].sel = dir_tab[k].e_sel;
                pending_results[$].trn = dir_tab[k].e_trn;
                pending_results[$].pred = dir_tab[k].e_pred;
                pending_results[$].err = dir_tab[k].e_err;
            end
        end
        drain();

        // random phases over settings and idle patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_all(31'd167772, 4'd4, 17'd8, 20'd3, 16'd1, 7'd50, 16'd2);
                1: set_all(31'h7FFF_FFFF, 4'd8, 17'd65536, 20'hFFFFF, 16'hFFFF, 7'd100,
                           16'hFFFF);
                2: set_all(31'd0, 4'd0, 17'd0, 20'd0, 16'd0, 7'd0, 16'd1);
                3: set_all(31'($urandom), 4'd15, 17'd1, 20'($urandom), 16'($urandom),
                           7'($urandom_range(100)), 16'd1);
                4: set_all(31'($urandom_range(32'h0100_0000)), 4'($urandom_range(8, 1)),
                           17'($urandom_range(16, 2)), 20'($urandom), 16'($urandom),
                           7'($urandom_range(100)), 16'($urandom_range(3, 1)));
                default: set_all(31'($urandom_range(32'h0040_0000)), 4'd3, 17'h1FFFF,
                                 20'($urandom), 16'($urandom), 7'($urandom_range(100)),
                                 16'd65535);
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
                default: begin src_idle_pct = 24; snk_stall_pct = 24; end
            endcase
            random_rows(85);
            drain();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/slre_pkg.sv
hw/rtl/slre_sample_if.sv
hw/rtl/slre_result_if.sv
hw/rtl/slre_cell.sv
hw/rtl/slre_mod.sv
hw/rtl/sgd_linear_regression_engine_top.sv
dv/tb_sgd_linear_regression_engine_top.sv
